// ===== hw/rtl/bfc_pkg.sv =====
// ----------------------------------------------------------------------------
// bfc_pkg: shared definitions for the bitcrusher fold/clip block
// Constants, register indexes, sequencer states, divider interface types and
// small helper functions used by the top level and the divider.
// ----------------------------------------------------------------------------
package bfc_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int OUT_BITS    = SAMPLE_BITS + 1;
  localparam int LIMIT_BITS  = SAMPLE_BITS - 1;
  localparam int MAX_HOLD    = 24;
  localparam int MIX_DIV     = 20;
  localparam int CTRL_BITS   = 5;
  localparam int ACC_BITS    = 30;
  localparam int DIV_BITS    = SAMPLE_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_BITS + 1);
  localparam int CFG_IDX_W   = 3;

  // divide by 20 as a quarter followed by a reciprocal multiply by 1/5
  localparam int                    MIX_M_BITS = ACC_BITS - 3;
  localparam int                    MIX_SHIFT  = 29;
  localparam logic [MIX_M_BITS-1:0] MIX_RECIP  = 27'd107374183;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOLD_MODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LEVEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRY_STEP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WET_STEP    = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LIMIT,
    S_FOLD_WAIT,
    S_FOLD_FIX,
    S_MUL_WET,
    S_MUL_DRY,
    S_MIX_ABS,
    S_MIX_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                   start;
    logic [DIV_BITS-1:0]    dividend;
    logic [SAMPLE_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [SAMPLE_BITS-1:0] remainder;
  } div_stat_t;

  function automatic logic [CTRL_BITS-1:0] clamp_range(
    input logic [CTRL_BITS-1:0] v,
    input logic [CTRL_BITS-1:0] lo,
    input logic [CTRL_BITS-1:0] hi
  );
    logic [CTRL_BITS-1:0] r;
    r = v;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  // keep the top res bits of a sample
  function automatic logic [SAMPLE_BITS-1:0] keep_mask(input logic [CTRL_BITS-1:0] res);
    logic [CTRL_BITS-1:0] shift;
    shift = CTRL_BITS'(SAMPLE_BITS) - res;
    return {SAMPLE_BITS{1'b1}} << shift;
  endfunction

endpackage

// ===== hw/rtl/bfc_div.sv =====
// ----------------------------------------------------------------------------
// bfc_div: restoring divider
// Shifts the dividend through one bit per cycle and leaves the remainder;
// used for the fold modulo.
// ----------------------------------------------------------------------------
module bfc_div (
  input  logic              clk,
  input  logic              rst,
  input  bfc_pkg::div_req_t req,
  output bfc_pkg::div_stat_t stat
);
  import bfc_pkg::*;

  logic [DIV_BITS-1:0]    quo;
  logic [SAMPLE_BITS-1:0] rem;
  logic [SAMPLE_BITS-1:0] divisor;
  logic [DIV_CNT_W-1:0]   count;
  logic                   done;

  logic [SAMPLE_BITS:0]   rem_sh;
  logic [SAMPLE_BITS:0]   rem_diff;
  logic                   fits;

  assign rem_sh   = {rem, quo[DIV_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign fits     = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (req.start) begin
      count <= DIV_CNT_W'(DIV_BITS);
      done  <= 1'b0;
    end else if (count != '0) begin
      count <= count - 1'b1;
      done  <= (count == DIV_CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (count != '0) begin
      quo <= {quo[DIV_BITS-2:0], fits};
      rem <= fits ? rem_diff[SAMPLE_BITS-1:0] : rem_sh[SAMPLE_BITS-1:0];
    end
  end

  assign stat.done      = done;
  assign stat.remainder = rem;

endmodule

// ===== hw/rtl/bitcrusher_fold_clip.sv =====
// ----------------------------------------------------------------------------
// bitcrusher_fold_clip: sample-and-hold bitcrusher with clip or fold limit
// Mixes each input with a held, limited, bit-reduced sample, or passes it when disabled.
//
// Usage:
//   Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data);
//   write it only while no transaction is in flight.
//   Input and output are valid/ready channels carrying one signed sample per
//   transaction. in_ready is high only while the sequencer is idle.
//   When disabled, an accepted sample goes straight to the done step; when
//   enabled, it passes the limit, two multiply and two mix steps. A fold
//   adds a wait on the restoring divider and a fix step for the modulo; the
//   division of the mix by 20 takes a magnitude step and a reciprocal multiply
//   step. A new sample is taken only once the last one has left the sequencer.
//   A finished result sits in the output register; if the receiver stalls,
//   the sequencer waits in its last step until that register is free.
//   Reset restores the register defaults, clears the hold counter and the
//   held sample, and empties the output register.
// ----------------------------------------------------------------------------
module bitcrusher_fold_clip (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [bfc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bfc_pkg::LIMIT_BITS-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [bfc_pkg::SAMPLE_BITS-1:0] sample_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [bfc_pkg::OUT_BITS-1:0]  sample_out
);
  import bfc_pkg::*;

  logic                   enable;
  logic                   fold_mode;
  logic [CTRL_BITS-1:0]   resolution;
  logic [CTRL_BITS-1:0]   hold_period;
  logic [LIMIT_BITS-1:0]  limit_level;
  logic [CTRL_BITS-1:0]   dry_step;
  logic [CTRL_BITS-1:0]   wet_step;

  state_t state, state_next;
  logic [CTRL_BITS-1:0]          hold_count, hold_count_next;
  logic signed [SAMPLE_BITS-1:0] held_sample, held_sample_next;
  logic signed [SAMPLE_BITS-1:0] x, x_next;
  logic                          cap, cap_next;
  logic                          neg, neg_next;
  logic signed [ACC_BITS-1:0]    acc, acc_next;
  logic signed [OUT_BITS-1:0]    res, res_next;

  div_req_t  div_req;
  div_stat_t div_st;

  logic [CTRL_BITS-1:0]   period_c, wet_c, dry_c, res_c, count_inc;
  logic                   cap_now;
  logic [SAMPLE_BITS-1:0] mag_x, lim_ext, lim2, fold_y, fold_r;
  logic signed [SAMPLE_BITS-1:0] reduced;
  logic [ACC_BITS-1:0]    acc_mag;
  logic [2*MIX_M_BITS-1:0] mix_prod;
  logic [OUT_BITS-1:0]    quo;

  bfc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .stat (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      fold_mode   <= 1'b1;
      resolution  <= CTRL_BITS'(8);
      hold_period <= CTRL_BITS'(1);
      limit_level <= {LIMIT_BITS{1'b1}};
      dry_step    <= CTRL_BITS'(5);
      wet_step    <= CTRL_BITS'(15);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ENABLE:      enable      <= cfg_data[0];
        REG_FOLD_MODE:   fold_mode   <= cfg_data[0];
        REG_RESOLUTION:  resolution  <= cfg_data[CTRL_BITS-1:0];
        REG_HOLD_PERIOD: hold_period <= cfg_data[CTRL_BITS-1:0];
        REG_LIMIT_LEVEL: limit_level <= cfg_data;
        REG_DRY_STEP:    dry_step    <= cfg_data[CTRL_BITS-1:0];
        REG_WET_STEP:    wet_step    <= cfg_data[CTRL_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign period_c  = clamp_range(hold_period, CTRL_BITS'(1), CTRL_BITS'(MAX_HOLD));
  assign wet_c     = clamp_range(wet_step, '0, CTRL_BITS'(MIX_DIV));
  assign dry_c     = clamp_range(dry_step, '0, CTRL_BITS'(MIX_DIV));
  assign res_c     = clamp_range(resolution, CTRL_BITS'(1), CTRL_BITS'(SAMPLE_BITS));
  assign count_inc = hold_count + 1'b1;
  assign cap_now   = count_inc >= period_c;

  assign mag_x    = x[SAMPLE_BITS-1] ? (~x + 1'b1) : x;
  assign lim_ext  = {1'b0, limit_level};
  assign lim2     = {limit_level, 1'b0};
  assign fold_y   = div_st.remainder + 1'b1;
  assign fold_r   = (fold_y > lim_ext) ? (lim2 - fold_y) : fold_y;
  assign reduced  = held_sample & keep_mask(res_c);
  assign acc_mag  = acc[ACC_BITS-1] ? (~acc + 1'b1) : acc;
  assign mix_prod = acc[ACC_BITS-2:2] * MIX_RECIP;
  assign quo      = mix_prod[MIX_SHIFT+OUT_BITS-1:MIX_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      hold_count  <= '0;
      held_sample <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      hold_count  <= hold_count_next;
      held_sample <= held_sample_next;
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    x   <= x_next;
    cap <= cap_next;
    neg <= neg_next;
    acc <= acc_next;
    res <= res_next;
    if (state == S_DONE && (!out_valid || out_ready)) begin
      sample_out <= res;
    end
  end

  always_comb begin
    state_next       = state;
    hold_count_next  = hold_count;
    held_sample_next = held_sample;
    x_next           = x;
    cap_next         = cap;
    neg_next         = neg;
    acc_next         = acc;
    res_next         = res;
    in_ready         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          x_next = sample_in;
          if (enable) begin
            cap_next        = cap_now;
            hold_count_next = cap_now ? '0 : count_inc;
            state_next      = S_LIMIT;
          end else begin
            res_next   = OUT_BITS'(sample_in);
            state_next = S_DONE;
          end
        end
      end
      S_LIMIT: begin
        neg_next   = x[SAMPLE_BITS-1];
        state_next = S_MUL_WET;
        if (cap) begin
          priority if (mag_x <= lim_ext) begin
            held_sample_next = x;
          end else if (limit_level == '0) begin
            held_sample_next = '0;
          end else if (!fold_mode) begin
            held_sample_next = x[SAMPLE_BITS-1] ? -$signed(lim_ext) : $signed(lim_ext);
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_BITS'(mag_x - 1'b1);
            div_req.divisor  = lim2;
            state_next       = S_FOLD_WAIT;
          end
        end
      end
      S_FOLD_WAIT: begin
        if (div_st.done) state_next = S_FOLD_FIX;
      end
      S_FOLD_FIX: begin
        held_sample_next = neg ? -$signed(fold_r) : $signed(fold_r);
        state_next       = S_MUL_WET;
      end
      S_MUL_WET: begin
        acc_next   = ACC_BITS'(reduced) * ACC_BITS'($signed({1'b0, wet_c}));
        state_next = S_MUL_DRY;
      end
      S_MUL_DRY: begin
        acc_next   = acc + ACC_BITS'(x) * ACC_BITS'($signed({1'b0, dry_c}));
        state_next = S_MIX_ABS;
      end
      S_MIX_ABS: begin
        neg_next   = acc[ACC_BITS-1];
        acc_next   = $signed(acc_mag);
        state_next = S_MIX_DIV;
      end
      S_MIX_DIV: begin
        res_next   = neg ? -$signed(quo) : $signed(quo);
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while sequencer busy");

  a_hold_count_range: assert property (@(posedge clk) disable iff (rst)
    hold_count < CTRL_BITS'(MAX_HOLD))
    else $error("hold counter out of range");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == S_FOLD_WAIT)
    else $error("divider finished outside the fold wait step");
`endif

endmodule
